FILE: rtl/core/rcts_pkg.sv
// shared constants for the read cache tag store
`default_nettype none
package rcts_pkg;
    localparam int SLOTS_DEF = 64;
    localparam int KEY_W = 40;
    localparam int STAMP_W = 64;
    localparam int CNT_W = 32;
    localparam int RAND_W = 64;

    localparam logic [RAND_W-1:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [RAND_W-1:0] LCG_INC = 64'd1442695040888963407;
    localparam logic [RAND_W-1:0] RAND_SEED = 64'h9e3779b97f4a7c15;
    localparam int RAND_SHIFT = 33;
    localparam int RAND_BITS = RAND_W - RAND_SHIFT;
    localparam logic [CNT_W-1:0] HIT_LAT_RST = 32'd1000;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] POL_CLOCK = 2'd0;
    localparam logic [1:0] POL_RANDOM = 2'd1;
    localparam logic [1:0] POL_LRU = 2'd2;
    localparam logic [1:0] POL_2Q = 2'd3;

    localparam logic [1:0] REG_ACTIVE_SLOTS = 2'd0;
    localparam logic [1:0] REG_EVICT_POLICY = 2'd1;
    localparam logic [1:0] REG_HIT_LATENCY = 2'd2;

    localparam logic MODE_INVALIDATE = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/core/rcts_tag_mem.sv
// key and recency stamp memory, one write and one registered read port
`default_nettype none
module rcts_tag_mem
    import rcts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IW = 6
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [IW-1:0]      wr_addr,
    input  wire logic [KEY_W-1:0]   wr_key,
    input  wire logic [STAMP_W-1:0] wr_stamp,
    input  wire logic [IW-1:0]      rd_addr,
    output logic      [KEY_W-1:0]   rd_key,
    output logic      [STAMP_W-1:0] rd_stamp
);
    logic [KEY_W-1:0]   key_mem [SLOTS];
    logic [STAMP_W-1:0] stamp_mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            stamp_mem[wr_addr] <= wr_stamp;
        end
        rd_key <= key_mem[rd_addr];
        rd_stamp <= stamp_mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/rcts_rand.sv
// lcg random victim unit: shared 32x32 multiplier, then bit-serial modulo
`default_nettype none
module rcts_rand
    import rcts_pkg::*;
#(
    parameter int CAP_W = 7,
    parameter int IW = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [CAP_W-1:0] cap,
    output logic                  done,
    output logic      [IW-1:0]    victim
);
    typedef enum logic [5:0] {
        R_IDLE = 6'b000001,
        R_MUL0 = 6'b000010,
        R_MUL1 = 6'b000100,
        R_MUL2 = 6'b001000,
        R_ADD  = 6'b010000,
        R_MOD  = 6'b100000
    } rphase_t;

    rphase_t               phase_reg;
    logic [RAND_W-1:0]     state_reg;
    logic [RAND_W-1:0]     state_next;
    logic [RAND_W-1:0]     acc_reg;
    logic [RAND_BITS-1:0]  quo_reg;
    logic [CAP_W-1:0]      rem_reg;
    logic [4:0]            bit_reg;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           prod;
    logic [CAP_W:0]        trial;
    logic [CAP_W:0]        rem_next;

    always_comb begin
        mul_a = state_reg[31:0];
        mul_b = LCG_MUL[31:0];
        case (phase_reg)
            R_MUL1: mul_b = LCG_MUL[63:32];
            R_MUL2: mul_a = state_reg[63:32];
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;
    assign state_next = acc_reg + LCG_INC;
    assign trial = {rem_reg, quo_reg[RAND_BITS-1]};
    assign rem_next = (trial >= {1'b0, cap}) ? trial - {1'b0, cap} : trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= R_IDLE;
            state_reg <= RAND_SEED;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            case (phase_reg)
                R_IDLE: begin
                    if (start) phase_reg <= R_MUL0;
                end
                R_MUL0: begin
                    acc_reg <= prod;
                    phase_reg <= R_MUL1;
                end
                R_MUL1: begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
                    phase_reg <= R_MUL2;
                end
                R_MUL2: begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
                    phase_reg <= R_ADD;
                end
                R_ADD: begin
                    state_reg <= state_next;
                    quo_reg <= state_next[RAND_W-1:RAND_SHIFT];
                    rem_reg <= '0;
                    bit_reg <= 5'(RAND_BITS - 1);
                    phase_reg <= R_MOD;
                end
                R_MOD: begin
                    rem_reg <= rem_next[CAP_W-1:0];
                    quo_reg <= {quo_reg[RAND_BITS-2:0], 1'b0};
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0) begin
                        victim <= rem_next[IW-1:0];
                        done <= 1'b1;
                        phase_reg <= R_IDLE;
                    end
                end
                default: phase_reg <= R_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/read_cache_tag_store_with_eviction_core.sv
// Tag-only read cache with CLOCK, random, LRU and 2Q eviction. One transaction
// is handled at a time. Lookup walks the slots one per cycle through the read
// port of the tag memory. A miss on a full cache adds the victim search: CLOCK
// steps one slot per cycle, LRU and 2Q make a second pass over the stamp
// memory, and random makes three passes through one 32x32 multiplier, then a
// 31-step modulo. With active_slots zero every transaction goes straight to
// the response and changes nothing.
`default_nettype none
module read_cache_tag_store_with_eviction_core
    import rcts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [39:0]   s_tdata,  // page_number
    input  wire logic [0:0]    s_tuser,  // mode
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic      [103:0]  m_tdata   // hit, latency, hit_count, miss_count
);
    localparam int CAP_W = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOOK = 7'b0000010,
        ST_CLK  = 7'b0000100,
        ST_RND  = 7'b0001000,
        ST_OLD  = 7'b0010000,
        ST_WR   = 7'b0100000,
        ST_RESP = 7'b1000000
    } state_t;

    state_t               state_reg;
    logic [6:0]           active_reg;
    logic [1:0]           policy_reg;
    logic [CNT_W-1:0]     hit_lat_reg;
    logic                 mode_reg;
    logic [KEY_W-1:0]     page_reg;
    logic [CAP_W-1:0]     scan_reg;
    logic                 pv_reg;
    logic [IW-1:0]        pidx_reg;
    logic [IW-1:0]        victim_reg;
    logic                 miss_reg;
    logic                 hit_res_reg;
    logic [CNT_W-1:0]     lat_res_reg;
    logic [SLOTS-1:0]     valid_reg;
    logic [SLOTS-1:0]     ref_reg;
    logic [CAP_W-1:0]     fill_reg;
    logic [IW-1:0]        hand_reg;
    logic [STAMP_W-1:0]   tick_reg;
    logic [CNT_W-1:0]     hits_reg;
    logic [CNT_W-1:0]     misses_reg;
    logic [STAMP_W-1:0]   any_min_reg;
    logic [IW-1:0]        any_pick_reg;
    logic [STAMP_W-1:0]   un_min_reg;
    logic [IW-1:0]        un_pick_reg;
    logic                 have_un_reg;
    logic                 rand_start_reg;
    logic                 m_tvalid_reg;
    logic [103:0]         m_tdata_reg;

    logic [31:0]          cap32;
    logic [CAP_W-1:0]     cap;
    logic [CAP_W-1:0]     hand_inc;
    logic [KEY_W-1:0]     rd_key;
    logic [STAMP_W-1:0]   rd_stamp;
    logic                 wr_en;
    logic                 rand_done;
    logic [IW-1:0]        rand_victim;
    logic                 scan_end;

    assign cap32 = ({25'd0, active_reg} > 32'(SLOTS)) ? 32'(SLOTS) : {25'd0, active_reg};
    assign cap = cap32[CAP_W-1:0];
    assign hand_inc = CAP_W'(hand_reg) + CAP_W'(1);
    assign scan_end = (scan_reg == cap) && !pv_reg;
    assign wr_en = (state_reg == ST_WR);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    rcts_tag_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (victim_reg),
        .wr_key   (page_reg),
        .wr_stamp (tick_reg + STAMP_W'(1)),
        .rd_addr  (scan_reg[IW-1:0]),
        .rd_key   (rd_key),
        .rd_stamp (rd_stamp)
    );

    rcts_rand #(.CAP_W(CAP_W), .IW(IW)) u_rand (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rand_start_reg),
        .cap     (cap),
        .done    (rand_done),
        .victim  (rand_victim)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            active_reg <= '0;
            policy_reg <= POL_CLOCK;
            hit_lat_reg <= HIT_LAT_RST;
            valid_reg <= '0;
            ref_reg <= '0;
            fill_reg <= '0;
            hand_reg <= '0;
            tick_reg <= '0;
            hits_reg <= '0;
            misses_reg <= '0;
            pv_reg <= 1'b0;
            rand_start_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rand_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready && state_reg != ST_RESP) m_tvalid_reg <= 1'b0;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ACTIVE_SLOTS: active_reg <= cfg_wdata[6:0];
                    REG_EVICT_POLICY: policy_reg <= cfg_wdata[1:0];
                    REG_HIT_LATENCY:  hit_lat_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg <= s_tuser[0];
                        page_reg <= s_tdata;
                        hit_res_reg <= 1'b0;
                        lat_res_reg <= '0;
                        miss_reg <= 1'b0;
                        scan_reg <= '0;
                        pv_reg <= 1'b0;
                        state_reg <= (cap == '0) ? ST_RESP : ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (scan_reg < cap) begin
                        scan_reg <= scan_reg + CAP_W'(1);
                        pv_reg <= 1'b1;
                        pidx_reg <= scan_reg[IW-1:0];
                    end else begin
                        pv_reg <= 1'b0;
                    end
                    if (pv_reg && valid_reg[pidx_reg] && rd_key == page_reg) begin
                        victim_reg <= pidx_reg;
                        hit_res_reg <= 1'b1;
                        if (mode_reg == MODE_INVALIDATE) begin
                            valid_reg[pidx_reg] <= 1'b0;
                            ref_reg[pidx_reg] <= 1'b0;
                            state_reg <= ST_RESP;
                        end else begin
                            lat_res_reg <= hit_lat_reg;
                            if (hits_reg != CNT_MAX) hits_reg <= hits_reg + CNT_W'(1);
                            state_reg <= ST_WR;
                        end
                    end else if (scan_end) begin
                        if (mode_reg == MODE_INVALIDATE) begin
                            state_reg <= ST_RESP;
                        end else begin
                            miss_reg <= 1'b1;
                            if (misses_reg != CNT_MAX) misses_reg <= misses_reg + CNT_W'(1);
                            if (fill_reg < cap) begin
                                victim_reg <= fill_reg[IW-1:0];
                                fill_reg <= fill_reg + CAP_W'(1);
                                state_reg <= ST_WR;
                            end else begin
                                case (policy_reg)
                                    POL_RANDOM: begin
                                        rand_start_reg <= 1'b1;
                                        state_reg <= ST_RND;
                                    end
                                    POL_LRU, POL_2Q: begin
                                        scan_reg <= '0;
                                        any_min_reg <= '1;
                                        any_pick_reg <= '0;
                                        un_min_reg <= '1;
                                        un_pick_reg <= '0;
                                        have_un_reg <= 1'b0;
                                        state_reg <= ST_OLD;
                                    end
                                    default: begin
                                        if (CAP_W'(hand_reg) >= cap) hand_reg <= '0;
                                        state_reg <= ST_CLK;
                                    end
                                endcase
                            end
                        end
                    end
                end
                ST_CLK: begin
                    // second chance: strip the reference bit and move on
                    hand_reg <= (hand_inc >= cap) ? '0 : hand_inc[IW-1:0];
                    if (!valid_reg[hand_reg] || !ref_reg[hand_reg]) begin
                        victim_reg <= hand_reg;
                        state_reg <= ST_WR;
                    end else begin
                        ref_reg[hand_reg] <= 1'b0;
                    end
                end
                ST_RND: begin
                    if (rand_done) begin
                        victim_reg <= rand_victim;
                        state_reg <= ST_WR;
                    end
                end
                ST_OLD: begin
                    if (scan_reg < cap) begin
                        scan_reg <= scan_reg + CAP_W'(1);
                        pv_reg <= 1'b1;
                        pidx_reg <= scan_reg[IW-1:0];
                    end else begin
                        pv_reg <= 1'b0;
                    end
                    if (pv_reg) begin
                        if (!valid_reg[pidx_reg]) begin
                            victim_reg <= pidx_reg;
                            state_reg <= ST_WR;
                        end else begin
                            if (rd_stamp < any_min_reg) begin
                                any_min_reg <= rd_stamp;
                                any_pick_reg <= pidx_reg;
                            end
                            if (!ref_reg[pidx_reg] && rd_stamp < un_min_reg) begin
                                un_min_reg <= rd_stamp;
                                un_pick_reg <= pidx_reg;
                                have_un_reg <= 1'b1;
                            end
                        end
                    end else if (scan_end) begin
                        victim_reg <= (policy_reg == POL_2Q && have_un_reg) ?
                            un_pick_reg : any_pick_reg;
                        state_reg <= ST_WR;
                    end
                end
                ST_WR: begin
                    valid_reg[victim_reg] <= 1'b1;
                    ref_reg[victim_reg] <= miss_reg ? (policy_reg != POL_2Q) : 1'b1;
                    tick_reg <= tick_reg + STAMP_W'(1);
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {7'd0, misses_reg, hits_reg, lat_res_reg, hit_res_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
